// ===== design/postfix_stack_evaluator_macros.svh =====
// Assertion helpers for the postfix evaluator
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pse_pkg.sv =====
`timescale 1ns / 1ps
package pse_pkg;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int FRAC_BITS_DEF   = 32;
  localparam int DATA_W          = 64;

  typedef enum logic [2:0] {
    FN_LIT = 3'd0, FN_ADD = 3'd1, FN_SUB = 3'd2, FN_MUL = 3'd3,
    FN_DIV = 3'd4, FN_REM = 3'd5, FN_SQR = 3'd6, FN_NOP = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_MISSING = 3'd1, ST_DIV0 = 3'd2, ST_LEFT = 3'd3,
    ST_OVERFLOW = 3'd4, ST_SAT = 3'd5
  } status_t;

  // Request to and reply from the shared arithmetic unit
  typedef struct packed {
    logic        start;
    func_t       op;
    logic [63:0] left;
    logic [63:0] right;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] value;
  } alu_rsp_t;
endpackage

// ===== design/pse_ram.sv =====
`timescale 1ns / 1ps
module pse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/pse_alu.sv =====
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_macros.svh"
module pse_alu #(
  parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pse_pkg::alu_req_t req,
  output pse_pkg::alu_rsp_t rsp
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MULF, S_DIV, S_FIN} state_t;

  state_t        state_r;
  pse_pkg::func_t op_r;
  logic          neg_r, lneg_r, sat_r, done_r;
  logic [63:0]   a_r, b_r, val_r;
  logic [127:0]  acc_r;    // product, or quotient during divide
  logic [127:0]  num_r;    // dividend shift register
  logic [63:0]   rem_r;
  logic [1:0]    pp_r;     // partial product index
  logic [7:0]    cnt_r;

  logic [63:0]   mag_l, mag_r;
  logic [31:0]   pa, pb;
  logic [63:0]   pprod;
  logic [64:0]   rem_sh, rem_sub;
  logic [127:0]  mag_res;
  logic [127:0]  shifted;
  logic [63:0]   sum;
  logic          add_ovf;
  logic          is_addsub;

  assign mag_l = req.left[63] ? (64'd0 - req.left) : req.left;
  assign mag_r = req.right[63] ? (64'd0 - req.right) : req.right;
  assign is_addsub = (req.op == pse_pkg::FN_ADD) || (req.op == pse_pkg::FN_SUB);

  // One 32x32 multiplier, four passes
  assign pa    = pp_r[0] ? a_r[63:32] : a_r[31:0];
  assign pb    = pp_r[1] ? b_r[63:32] : b_r[31:0];
  assign pprod = 64'(pa) * 64'(pb);

  // Restoring divide step
  assign rem_sh  = {rem_r, num_r[127]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  assign shifted = acc_r >> FRAC_BITS;
  assign mag_res = (op_r == pse_pkg::FN_REM) ? {64'd0, rem_r} :
                   (op_r == pse_pkg::FN_DIV) ? acc_r : shifted;

  assign sum = (req.op == pse_pkg::FN_SUB) ? req.left - req.right : req.left + req.right;
  assign add_ovf = ((req.op == pse_pkg::FN_SUB) ? (req.left[63] != req.right[63])
                                                : (req.left[63] == req.right[63]))
                   && (sum[63] != req.left[63]);

  // Sequence the shared unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      // Pulse done for an add or subtract straight from idle, or from S_FIN at the end of a multiply or divide pass
      done_r <= ((state_r == S_IDLE) && req.start && is_addsub) || (state_r == S_FIN);
      case (state_r)
        S_IDLE: if (req.start) begin
          op_r   <= req.op;
          neg_r  <= req.left[63] ^ req.right[63];
          lneg_r <= req.left[63];
          a_r    <= mag_l;
          b_r    <= mag_r;
          acc_r  <= '0;
          pp_r   <= 2'd0;
          rem_r  <= '0;
          num_r  <= (req.op == pse_pkg::FN_REM) ? {mag_l, 64'd0}
                                                : ({64'd0, mag_l} << FRAC_BITS);
          cnt_r  <= (req.op == pse_pkg::FN_REM) ? 8'd64 : 8'd0;
          if (is_addsub) begin
            val_r  <= add_ovf ? (req.left[63] ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF) : sum;
            sat_r  <= add_ovf;
          end else if (req.op == pse_pkg::FN_REM || req.op == pse_pkg::FN_DIV) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= acc_r + ({64'd0, pprod} << (7'(pp_r[0]) * 7'd32 + 7'(pp_r[1]) * 7'd32));
          pp_r  <= pp_r + 2'd1;
          if (pp_r == 2'd3) state_r <= S_FIN;
        end
        S_DIV: begin
          num_r <= num_r << 1;
          if (rem_sh >= {1'b0, b_r}) begin
            rem_r <= rem_sub[63:0];
            acc_r <= {acc_r[126:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            acc_r <= {acc_r[126:0], 1'b0};
          end
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd127) state_r <= S_FIN;
        end
        S_FIN: begin
          state_r <= S_IDLE;
          if (op_r == pse_pkg::FN_REM) begin
            // Remainder takes the sign of the dividend
            sat_r <= 1'b0;
            val_r <= lneg_r ? 64'd0 - mag_res[63:0] : mag_res[63:0];
          end else if (neg_r) begin
            sat_r <= (mag_res[127:64] != 0) || (mag_res[63:0] > 64'h8000_0000_0000_0000);
            val_r <= ((mag_res[127:64] != 0) || (mag_res[63:0] > 64'h8000_0000_0000_0000))
                     ? 64'h8000_0000_0000_0000 : 64'd0 - mag_res[63:0];
          end else begin
            sat_r <= (mag_res[127:63] != 0);
            val_r <= (mag_res[127:63] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : mag_res[63:0];
          end
        end
        S_MULF: state_r <= S_FIN;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sat   = sat_r;
  assign rsp.value = val_r;

  `PSE_ASSERT_NXT(a_start_idle, clk, rst_n, req.start && state_r != S_IDLE, 1'b1)
  `PSE_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, state_r == S_IDLE)
  `PSE_ASSERT_NXT(a_fin_done, clk, rst_n, state_r == S_FIN, done_r)
endmodule

// ===== design/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports
// input   | in        | in_valid, in_ready, in_func, in_operand_value, in_end_of_expression
// result  | out       | out_valid, out_ready, out_answer, out_status
// Each token holds in_ready low until it is through; multiply and square run the
// partial-product passes and divide and remainder the one-bit-a-cycle divider in pse_alu.
// Operators read their operands from the stack RAM one pop per cycle; square pops only one.
// A token marked last passes through S_LOAD to read the stack, then holds in_ready low
// until its result is taken by out_ready.
// Reset clears the stack count and error; the stack RAM is not cleared.
`include "postfix_stack_evaluator_macros.svh"
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic signed [63:0] in_operand_value,
  input  logic        in_end_of_expression,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] out_answer,
  output logic [2:0]  out_status
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_POP1, S_POP2, S_CALC, S_WAIT, S_FINAL, S_LOAD, S_OUT
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  pse_pkg::status_t  err_r;
  pse_pkg::func_t    fn_r;
  logic              last_r;
  logic [63:0]       right_r;
  logic              ram_we;
  logic [AW-1:0]     waddr, raddr;
  logic [63:0]       wdata, rdata;
  pse_pkg::alu_req_t req;
  pse_pkg::alu_rsp_t rsp;
  logic              need2, ok_cnt;
  pse_pkg::func_t    in_fn;

  assign in_fn  = pse_pkg::func_t'(in_func);
  assign need2  = in_fn != pse_pkg::FN_SQR;
  assign ok_cnt = (cnt_r != '0) && (!need2 || cnt_r >= CW'(2));

  pse_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  pse_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_ready = (state_r == S_IDLE);
  assign raddr    = AW'(cnt_r - CW'(1));
  assign ram_we   = (in_valid && in_ready && err_r == pse_pkg::ST_OK && in_fn == pse_pkg::FN_LIT
                     && cnt_r < CW'(STACK_DEPTH)) || (state_r == S_WAIT && rsp.done);
  assign waddr    = AW'(cnt_r);
  assign wdata    = (state_r == S_WAIT) ? rsp.value : in_operand_value;

  assign req.start = (state_r == S_CALC);
  assign req.op    = fn_r;
  assign req.left  = (fn_r == pse_pkg::FN_SQR) ? right_r : rdata;
  assign req.right = right_r;

  // Sequence tokens through stack and shared unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      err_r     <= pse_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          fn_r   <= in_fn;
          last_r <= in_end_of_expression;
          if (err_r == pse_pkg::ST_OK && in_fn != pse_pkg::FN_LIT
              && in_fn != pse_pkg::FN_NOP && ok_cnt) state_r <= S_POP1;
          else state_r <= S_FINAL;
          if (err_r == pse_pkg::ST_OK) begin
            if (in_fn == pse_pkg::FN_LIT) begin
              if (cnt_r < CW'(STACK_DEPTH)) cnt_r <= cnt_r + CW'(1);
              else err_r <= pse_pkg::ST_OVERFLOW;
            end else if (in_fn != pse_pkg::FN_NOP && !ok_cnt) begin
              err_r <= pse_pkg::ST_MISSING;
            end
          end
        end
        S_POP1: begin
          cnt_r   <= cnt_r - CW'(1);
          state_r <= S_POP2;
        end
        S_POP2: begin
          right_r <= rdata;
          if (fn_r != pse_pkg::FN_SQR) cnt_r <= cnt_r - CW'(1);
          if ((fn_r == pse_pkg::FN_DIV || fn_r == pse_pkg::FN_REM) && rdata == 64'd0) begin
            err_r   <= pse_pkg::ST_DIV0;
            state_r <= S_FINAL;
          end else state_r <= S_CALC;
        end
        S_CALC: state_r <= S_WAIT;
        S_WAIT: if (rsp.done) begin
          cnt_r <= cnt_r + CW'(1);
          if (rsp.sat) err_r <= pse_pkg::ST_SAT;
          state_r <= S_FINAL;
        end
        // Return to idle, or for a last token read the top entry once the last write has landed
        S_FINAL: begin
          if (!last_r) state_r <= S_IDLE;
          else state_r <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          if (err_r != pse_pkg::ST_OK) begin
            out_status <= err_r;
            out_answer <= '0;
          end else if (cnt_r == '0) begin
            out_status <= pse_pkg::ST_MISSING;
            out_answer <= '0;
          end else if (cnt_r > CW'(1)) begin
            out_status <= pse_pkg::ST_LEFT;
            out_answer <= '0;
          end else begin
            out_status <= pse_pkg::ST_OK;
            out_answer <= rdata;
          end
          cnt_r   <= '0;
          err_r   <= pse_pkg::ST_OK;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PSE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `PSE_ASSERT_IMP(a_out_state, clk, rst_n, out_valid, state_r == S_OUT)
  `PSE_ASSERT_NXT(a_out_clear, clk, rst_n, out_valid && out_ready, cnt_r == '0)
endmodule

// ===== verif/tb_postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
module tb_postfix_stack_evaluator;
  localparam int DEPTH      = pse_pkg::STACK_DEPTH_DEF;
  localparam int FRAC       = pse_pkg::FRAC_BITS_DEF;
  localparam int ITEM_GOAL  = 1450;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 300;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE     = 64'h1 << FRAC;

  typedef struct {
    logic [63:0]      answer;
    pse_pkg::status_t status;
  } outcome_t;

  typedef struct {
    pse_pkg::func_t   fn;
    logic [63:0]      value;
    bit               last;
    bit               typed;
    logic [63:0]      answer;
    pse_pkg::status_t status;
  } token_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic signed [63:0] in_operand_value = '0;
  logic in_end_of_expression = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] out_answer;
  logic [2:0] out_status;

  // Own copy of the evaluator state
  logic [63:0]      model_stack [DEPTH];
  int               model_count;
  pse_pkg::status_t model_fault;

  outcome_t    pending_outcomes[$];
  token_row_t  directed_rows[$];
  int          mismatches;
  int          items_sent;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          timed_out;

  postfix_stack_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_operand_value(in_operand_value), .in_end_of_expression(in_end_of_expression),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_answer(out_answer), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Record only the first fault of an expression
  function automatic void note_fault(pse_pkg::status_t code);
    if (model_fault == pse_pkg::ST_OK) model_fault = code;
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Give a 128-bit magnitude its sign, clamping to the 64-bit range
  function automatic logic [63:0] signed_clamp(logic [127:0] mag, bit neg);
    if (neg) begin
      if (mag > {64'd0, NEG_MAX}) begin
        note_fault(pse_pkg::ST_SAT);
        return NEG_MAX;
      end
      return 64'd0 - mag[63:0];
    end
    if (mag > {64'd0, POS_MAX}) begin
      note_fault(pse_pkg::ST_SAT);
      return POS_MAX;
    end
    return mag[63:0];
  endfunction

  function automatic logic [63:0] fixed_sum(logic [63:0] a, logic [63:0] b, bit minus);
    logic [64:0] s;
    s = minus ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) begin
      note_fault(pse_pkg::ST_SAT);
      return a[63] ? NEG_MAX : POS_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] fixed_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> FRAC;
    return signed_clamp(p, a[63] ^ b[63]);
  endfunction

  function automatic logic [63:0] fixed_quotient(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = ({64'd0, abs64(a)} << FRAC) / {64'd0, abs64(b)};
    return signed_clamp(q, a[63] ^ b[63]);
  endfunction

  function automatic logic [63:0] fixed_remainder(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = abs64(a) % abs64(b);
    return a[63] ? (64'd0 - r) : r;
  endfunction

  // Apply one token to the stack, ignoring a skip token, or any token once a fault is recorded
  function automatic void apply_token(pse_pkg::func_t fn, logic [63:0] lit);
    logic [63:0] lhs, rhs, res;
    lhs = '0;
    if (model_fault != pse_pkg::ST_OK || fn == pse_pkg::FN_NOP) return;
    if (fn == pse_pkg::FN_LIT) begin
      if (model_count >= DEPTH) note_fault(pse_pkg::ST_OVERFLOW);
      else begin
        model_stack[model_count] = lit;
        model_count++;
      end
      return;
    end
    if (model_count == 0 || (fn != pse_pkg::FN_SQR && model_count < 2)) begin
      note_fault(pse_pkg::ST_MISSING);
      return;
    end
    model_count--;
    rhs = model_stack[model_count];
    if (fn != pse_pkg::FN_SQR) begin
      model_count--;
      lhs = model_stack[model_count];
    end
    case (fn)
      pse_pkg::FN_ADD: res = fixed_sum(lhs, rhs, 1'b0);
      pse_pkg::FN_SUB: res = fixed_sum(lhs, rhs, 1'b1);
      pse_pkg::FN_MUL: res = fixed_product(lhs, rhs);
      pse_pkg::FN_DIV, pse_pkg::FN_REM: begin
        if (rhs == '0) begin
          note_fault(pse_pkg::ST_DIV0);
          return;
        end
        res = (fn == pse_pkg::FN_DIV) ? fixed_quotient(lhs, rhs) : fixed_remainder(lhs, rhs);
      end
      default: res = fixed_product(rhs, rhs);
    endcase
    model_stack[model_count] = res;
    model_count++;
  endfunction

  // Close the expression and return its outcome
  function automatic outcome_t close_expression();
    outcome_t o;
    o.answer = '0;
    if (model_fault != pse_pkg::ST_OK) o.status = model_fault;
    else if (model_count == 0) o.status = pse_pkg::ST_MISSING;
    else if (model_count > 1) o.status = pse_pkg::ST_LEFT;
    else begin
      o.status = pse_pkg::ST_OK;
      o.answer = model_stack[0];
    end
    model_count = 0;
    model_fault = pse_pkg::ST_OK;
    return o;
  endfunction

  // Drive one token and hold it until the transfer
  task automatic send_token(pse_pkg::func_t fn, logic [63:0] v, bit last, bit typed = 0,
                            logic [63:0] ans = '0,
                            pse_pkg::status_t st = pse_pkg::ST_OK);
    outcome_t o;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_operand_value <= v;
    in_end_of_expression <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    apply_token(fn, v);
    if (last) begin
      o = close_expression();
      if (typed) begin
        o.answer = ans;
        o.status = st;
      end
      pending_outcomes.push_back(o);
    end
  endtask

  task automatic add_row(pse_pkg::func_t fn, logic [63:0] v, bit last, bit typed = 0,
                         logic [63:0] ans = '0, pse_pkg::status_t st = pse_pkg::ST_OK);
    token_row_t r;
    r.fn = fn; r.value = v; r.last = last; r.typed = typed; r.answer = ans; r.status = st;
    directed_rows.push_back(r);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return {{32{1'b0}}, 32'($urandom_range(0, 20))} << FRAC;
      3:       return 64'd0 - ({32'd0, 32'($urandom_range(1, 20))} << FRAC);
      4:       return {{32{1'($urandom_range(1))}}, $urandom};
      5:       return POS_MAX;
      6:       return NEG_MAX;
      7:       return $urandom_range(1) ? 64'd1 : 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A well-formed expression with random content
  task automatic send_expression();
    int depth, len;
    pse_pkg::func_t fn;
    depth = 0;
    len = $urandom_range(1, 12);
    for (int k = 0; k < len || depth != 1; k++) begin
      if (depth < 2 || ($urandom_range(2) == 0 && depth < 8)) begin
        if (depth >= 1 && $urandom_range(5) == 0) fn = pse_pkg::FN_SQR;
        else begin
          fn = pse_pkg::FN_LIT;
          depth++;
        end
      end else begin
        // Keep the slow divider to a modest share
        case ($urandom_range(9))
          0, 1, 2: fn = pse_pkg::FN_ADD;
          3, 4:    fn = pse_pkg::FN_SUB;
          5, 6:    fn = pse_pkg::FN_MUL;
          7:       fn = pse_pkg::FN_DIV;
          8:       fn = pse_pkg::FN_REM;
          default: fn = pse_pkg::FN_SQR;
        endcase
        if (fn != pse_pkg::FN_SQR) depth--;
      end
      send_token(fn, (fn == pse_pkg::FN_LIT || $urandom_range(1)) ? pick_value()
                                                                  : {$urandom, $urandom},
                 depth == 1 && k + 1 >= len);
    end
  endtask

  // Receiver: check each transfer against the oldest outcome, then pick ready
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: answer %h status %0d", out_answer, out_status);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_answer !== want.answer || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected answer %h status %0d, got answer %h status %0d",
                     want.answer, want.status, out_answer, out_status);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    model_count = 0;
    model_fault = pse_pkg::ST_OK;
    mismatches = 0;
    items_sent = 0;
    stall_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 85;

    // Directed tokens: extremes, each operation and each fault
    add_row(pse_pkg::FN_LIT, POS_MAX, 1, 1, POS_MAX, pse_pkg::ST_OK);
    add_row(pse_pkg::FN_LIT, NEG_MAX, 1, 1, NEG_MAX, pse_pkg::ST_OK);
    add_row(pse_pkg::FN_ADD, '0, 1, 1, '0, pse_pkg::ST_MISSING);
    add_row(pse_pkg::FN_LIT, ONE, 0);
    add_row(pse_pkg::FN_LIT, '0, 0);
    add_row(pse_pkg::FN_DIV, '0, 1, 1, '0, pse_pkg::ST_DIV0);
    add_row(pse_pkg::FN_LIT, POS_MAX, 0);
    add_row(pse_pkg::FN_LIT, POS_MAX, 0);
    add_row(pse_pkg::FN_ADD, '0, 1, 1, '0, pse_pkg::ST_SAT);
    add_row(pse_pkg::FN_LIT, 3 * ONE, 0);
    add_row(pse_pkg::FN_LIT, 2 * ONE + 64'h8000_0000, 0);
    add_row(pse_pkg::FN_SUB, '0, 0);
    add_row(pse_pkg::FN_LIT, 64'd0 - 2 * ONE, 0);
    add_row(pse_pkg::FN_MUL, '0, 1);
    add_row(pse_pkg::FN_LIT, 64'd0 - 7 * ONE, 0);
    add_row(pse_pkg::FN_LIT, 2 * ONE, 0);
    add_row(pse_pkg::FN_REM, '0, 1);
    add_row(pse_pkg::FN_LIT, 64'd5, 0);
    add_row(pse_pkg::FN_LIT, 64'd3, 1, 1, '0, pse_pkg::ST_LEFT);
    add_row(pse_pkg::FN_NOP, '1, 1, 1, '0, pse_pkg::ST_MISSING);
    add_row(pse_pkg::FN_LIT, 64'd0 - 3 * ONE - 64'd1, 0);
    add_row(pse_pkg::FN_SQR, '0, 1);
    add_row(pse_pkg::FN_LIT, 64'd0 - ONE, 0);
    add_row(pse_pkg::FN_LIT, 3 * ONE, 0);
    add_row(pse_pkg::FN_DIV, '0, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_token(directed_rows[i].fn, directed_rows[i].value, directed_rows[i].last,
                 directed_rows[i].typed, directed_rows[i].answer, directed_rows[i].status);
    // Fill the stack past its depth
    for (int k = 0; k <= DEPTH; k++)
      send_token(pse_pkg::FN_LIT, 64'(k), k == DEPTH, 1, '0, pse_pkg::ST_OVERFLOW);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL / 3 && send_idle_pct == 7) begin
        // Hold off until the result side has drained, then swap idling
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        send_idle_pct = 85;
        recv_idle_pct = 7;
      end else if (items_sent >= 2 * ITEM_GOAL / 3 && send_idle_pct == 85) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(19))
        0, 1: send_token(pse_pkg::func_t'($urandom_range(7)), {$urandom, $urandom},
                         1'($urandom_range(1)));
        2: begin
          // Possibly broken sequence: truncated, padded or well-formed expression
          repeat ($urandom_range(1, 4)) send_token(pse_pkg::FN_LIT, pick_value(), 0);
          send_token(pse_pkg::func_t'($urandom_range(1, 6)), '0, 1);
        end
        3: if ($urandom_range(9) == 0)
          for (int k = 0; k <= DEPTH; k++)
            send_token(pse_pkg::FN_LIT, pick_value(), k == DEPTH);
        default: send_expression();
      endcase
    end
    in_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/pse_pkg.sv
design/pse_ram.sv
design/pse_alu.sv
design/postfix_stack_evaluator.sv
verif/tb_postfix_stack_evaluator.sv
